[hdl/sorted_interval_table_top_assert.svh]
// Assertion macros used by the interval table top.
`ifndef SORTED_INTERVAL_TABLE_TOP_ASSERT_SVH
`define SORTED_INTERVAL_TABLE_TOP_ASSERT_SVH

// Checked on every edge once reset is released.
`define SIT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define SIT_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/sit_pkg.sv]
// Package: sizes, codes and types of the sorted interval table.
`default_nettype none
package sit_pkg;
	localparam int CAPACITY = 64;
	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);

	localparam int OP_W = 2;
	localparam int TIME_W = 11;
	localparam int ROOM_W = 16;
	localparam int STATUS_W = 3;
	localparam int ENTRY_W = 6;
	localparam int COUNT_W = 7;

	localparam logic [TIME_W-1:0] DAY_MINUTES = TIME_W'(24 * 60);

	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_FIND   = 2'd1;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

	localparam logic [STATUS_W-1:0] STAT_OK       = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_INVALID  = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_OVERLAP  = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 3'd4;

	typedef struct packed {
		logic [TIME_W-1:0] t_begin;
		logic [TIME_W-1:0] t_end;
		logic [ROOM_W-1:0] room;
	} entry_t;

	// Broadcast from the controller to every cell
	typedef struct packed {
		logic              cmp;
		logic              ins;
		logic              rem;
		logic [TIME_W-1:0] key;
		logic [TIME_W-1:0] probe;
		entry_t            fresh;
	} cell_cmd_t;

	// Registered compare results of one cell
	typedef struct packed {
		logic ge;
		logic match;
		logic endgt;
	} cell_flags_t;
endpackage
`default_nettype wire

[hdl/sit_cell.sv]
// One table slot: holds an entry, compares it with the key, shifts with its neighbours.
`default_nettype none
module sit_cell (
	input  wire                  clk,
	input  wire                  occ,
	input  sit_pkg::cell_cmd_t   cmd,
	input  wire                  prev_ge,
	input  sit_pkg::entry_t      prev_entry,
	input  sit_pkg::entry_t      next_entry,
	output sit_pkg::entry_t      entry,
	output sit_pkg::cell_flags_t flags
);
	import sit_pkg::*;

	entry_t      entry_q;
	cell_flags_t flags_q;

	always_ff @(posedge clk) begin
		if (cmd.cmp) begin
			// empty slots count as "at or after" so the slot search is monotone
			flags_q.ge    <= !occ || (entry_q.t_begin >= cmd.key);
			flags_q.match <= occ && (entry_q.t_begin == cmd.probe);
			flags_q.endgt <= entry_q.t_end > cmd.probe;
		end
		if (cmd.ins && flags_q.ge) begin
			entry_q <= prev_ge ? prev_entry : cmd.fresh;
		end else if (cmd.rem && flags_q.ge) begin
			entry_q <= next_entry;
		end
	end

	assign entry = entry_q;
	assign flags = flags_q;
endmodule
`default_nettype wire

[hdl/sorted_interval_table_top.sv]
// Sorted interval table: a compare state and an execute state over a row of compare-and-shift
// cells for each operation (insert, find, remove). In the compare state every cell compares its
// entry with the key and registers the outcome; in the execute state the controller encodes the
// slot or match position from those flags, settles the status and shifts the row up or down by
// one in a single step. A new beat is taken on the edge that ends the previous operation, not
// before, and the execute state holds while the output register is full and stalled; a result
// waits in the output register without holding up the next item's compare state. No clearing
// pass is needed after reset: slot occupancy follows from the entry count alone.
`default_nettype none
`include "sorted_interval_table_top_assert.svh"
module sorted_interval_table_top (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              in_valid,
	output logic                             in_stall,
	input  wire  [sit_pkg::OP_W-1:0]         opcode,
	input  wire  [sit_pkg::TIME_W-1:0]       begin_time,
	input  wire  [sit_pkg::TIME_W-1:0]       end_time,
	input  wire  [sit_pkg::ROOM_W-1:0]       room_tag,
	output logic                             out_valid,
	input  wire                              out_stall,
	output logic [sit_pkg::STATUS_W-1:0]     status,
	output logic [sit_pkg::ENTRY_W-1:0]      entry_index,
	output logic [sit_pkg::TIME_W-1:0]       found_begin,
	output logic [sit_pkg::TIME_W-1:0]       found_end,
	output logic [sit_pkg::ROOM_W-1:0]       found_room,
	output logic [sit_pkg::COUNT_W-1:0]      entry_count
);
	import sit_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_CMP  = 2'd1;
	localparam logic [1:0] S_EXE  = 2'd2;
	localparam int EBITS = $bits(entry_t);

	logic [1:0]        state_q;
	logic [OP_W-1:0]   op_q;
	logic [TIME_W-1:0] b_q;
	logic [TIME_W-1:0] e_q;
	logic [ROOM_W-1:0] room_q;
	logic [CNT_W-1:0]  count_q;

	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [IDX_W-1:0]    idx_q;
	entry_t              found_q;
	logic [CNT_W-1:0]    count_out_q;

	logic in_acc;
	logic exe_fire;

	cell_cmd_t   cmd;
	entry_t      ent [CAPACITY];
	cell_flags_t flg [CAPACITY];
	logic        prev_ge_w [CAPACITY];
	entry_t      prev_ent_w [CAPACITY];
	entry_t      next_ent_w [CAPACITY];
	logic [CAPACITY-1:0] occ_v;

	logic [CAPACITY-1:0] ge_v, match_v, endgt_v, slot_v, pred_v;
	logic [IDX_W-1:0]    slot_idx, match_idx;
	logic [EBITS-1:0]    found_bits;
	logic                overlap, any_match;

	logic [STATUS_W-1:0] res_status;
	logic [IDX_W-1:0]    res_idx;
	entry_t              res_found;
	logic [CNT_W-1:0]    cnt_next;
	logic                do_ins, do_rem;

	logic [IDX_W+ENTRY_W-1:0] idx_ext;
	logic [CNT_W+COUNT_W-1:0] cnt_ext;

	// handshake and sequencing
	assign exe_fire = (state_q == S_EXE) && (!out_valid_q || !out_stall);
	assign in_stall = !((state_q == S_IDLE) || exe_fire);
	assign in_acc   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: if (in_acc) state_q <= S_CMP;
				S_CMP:  state_q <= S_EXE;
				S_EXE: begin
					if (in_acc) state_q <= S_CMP;
					else if (exe_fire) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q   <= opcode;
			b_q    <= begin_time;
			e_q    <= end_time;
			room_q <= room_tag;
		end
	end

	// cell row
	assign cmd.cmp   = (state_q == S_CMP);
	assign cmd.ins   = exe_fire && do_ins;
	assign cmd.rem   = exe_fire && do_rem;
	assign cmd.key   = (op_q == OP_REMOVE) ? b_q : e_q;
	assign cmd.probe = b_q;
	assign cmd.fresh = '{t_begin: b_q, t_end: e_q, room: room_q};

	for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
		assign occ_v[k] = CNT_W'(k) < count_q;
		if (k == 0) begin : g_first
			assign prev_ge_w[k]  = 1'b0;
			assign prev_ent_w[k] = cmd.fresh;
		end else begin : g_mid
			assign prev_ge_w[k]  = flg[k-1].ge;
			assign prev_ent_w[k] = ent[k-1];
		end
		if (k == CAPACITY - 1) begin : g_last
			assign next_ent_w[k] = ent[k];
		end else begin : g_inner
			assign next_ent_w[k] = ent[k+1];
		end

		sit_cell u_cell (
			.clk        (clk),
			.occ        (occ_v[k]),
			.cmd        (cmd),
			.prev_ge    (prev_ge_w[k]),
			.prev_entry (prev_ent_w[k]),
			.next_entry (next_ent_w[k]),
			.entry      (ent[k]),
			.flags      (flg[k])
		);
	end

	// flag vectors, slot and match encoding
	always_comb begin
		for (int k = 0; k < CAPACITY; k++) begin
			ge_v[k]    = flg[k].ge;
			match_v[k] = flg[k].match;
			endgt_v[k] = flg[k].endgt;
		end
		// slot: first cell at or after the new end; predecessor: the one just before it
		slot_v[0] = ge_v[0];
		for (int k = 1; k < CAPACITY; k++) begin
			slot_v[k] = ge_v[k] && !ge_v[k-1];
		end
		for (int k = 0; k < CAPACITY - 1; k++) begin
			pred_v[k] = !ge_v[k] && ge_v[k+1];
		end
		pred_v[CAPACITY-1] = !ge_v[CAPACITY-1];

		slot_idx   = '0;
		match_idx  = '0;
		found_bits = '0;
		for (int k = 0; k < CAPACITY; k++) begin
			if (slot_v[k]) slot_idx |= IDX_W'(k);
			if (match_v[k]) match_idx |= IDX_W'(k);
			found_bits |= ent[k] & {EBITS{match_v[k]}};
		end
		overlap   = |(pred_v & endgt_v);
		any_match = |match_v;
	end

	// status of the operation in hand
	always_comb begin
		res_status = STAT_INVALID;
		res_idx    = '0;
		res_found  = '0;
		cnt_next   = count_q;
		do_ins     = 1'b0;
		do_rem     = 1'b0;
		case (op_q)
			OP_INSERT: begin
				if (b_q >= e_q || e_q > DAY_MINUTES) begin
					res_status = STAT_INVALID;
				end else if (overlap) begin
					res_status = STAT_OVERLAP;
				end else if (count_q == CNT_W'(CAPACITY)) begin
					res_status = STAT_FULL;
				end else begin
					res_status = STAT_OK;
					res_idx    = slot_idx;
					cnt_next   = count_q + CNT_W'(1);
					do_ins     = 1'b1;
				end
			end
			OP_FIND, OP_REMOVE: begin
				if (b_q > DAY_MINUTES) begin
					res_status = STAT_INVALID;
				end else if (!any_match) begin
					res_status = STAT_NOTFOUND;
				end else begin
					res_status = STAT_OK;
					res_idx    = match_idx;
					if (op_q == OP_FIND) begin
						res_found = entry_t'(found_bits);
					end else begin
						cnt_next = count_q - CNT_W'(1);
						do_rem   = 1'b1;
					end
				end
			end
			default: res_status = STAT_INVALID;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (exe_fire) begin
				count_q     <= cnt_next;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (exe_fire) begin
			status_q    <= res_status;
			idx_q       <= res_idx;
			found_q     <= res_found;
			count_out_q <= cnt_next;
		end
	end

	// fit index and count to the port widths
	assign idx_ext = {{ENTRY_W{1'b0}}, idx_q};
	assign cnt_ext = {{COUNT_W{1'b0}}, count_out_q};

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign entry_index = idx_ext[ENTRY_W-1:0];
	assign found_begin = found_q.t_begin;
	assign found_end   = found_q.t_end;
	assign found_room  = found_q.room;
	assign entry_count = cnt_ext[COUNT_W-1:0];

	`SIT_ASSERT_ALWAYS(a_count_bound, !arst_n || count_q <= CNT_W'(CAPACITY), "count above capacity")
	`SIT_ASSERT(a_match_unique, (state_q == S_EXE) |-> $onehot0(match_v), "several cells match")
	`SIT_ASSERT(a_slot_unique, (state_q == S_EXE) |-> $onehot0(slot_v), "insert slot not unique")
	`SIT_ASSERT(a_ins_count, (exe_fire && do_ins) |=> (count_q == $past(count_q) + CNT_W'(1)), "insert did not grow count")
	`SIT_ASSERT(a_cmp_stall, (state_q == S_CMP) |-> in_stall, "beat taken during compare")
endmodule
`default_nettype wire
